FILE: sv/spd_pkg.sv
// Shared types and constants for the sensor packet deframer.
// No dependencies; imported by every module of the block.
package spd_pkg;

    localparam logic [7:0] SYNC_A = 8'hFA;
    localparam logic [7:0] SYNC_B = 8'hFF;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [7:0] message_id;
        logic [7:0] payload_byte;
        logic [7:0] byte_index;
        logic       frame_end;
        logic       checksum_ok;
    } t_result;

    typedef struct packed {
        logic    valid;
        t_result res;
    } t_push;

endpackage

FILE: sv/spd_parser.sv
// Front part: preamble hunt, header capture, checksum accumulation.
// Depends on spd_pkg; pushes results into the spd_fifo queue.
module spd_parser (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_take,
    input  logic [7:0]    i_byte,
    output spd_pkg::t_push o_push
);
    import spd_pkg::*;

    typedef enum logic [2:0] {
        PH_HUNT0 = 3'd0,
        PH_HUNT1 = 3'd1,
        PH_ID    = 3'd2,
        PH_LEN   = 3'd3,
        PH_DATA  = 3'd4,
        PH_CSUM  = 3'd5
    } t_phase;

    t_phase     r_phase, n_phase;
    logic [7:0] r_id, n_id;
    logic [7:0] r_len, n_len;
    logic [7:0] r_seen, n_seen;
    logic [7:0] r_sum, n_sum;
    logic [7:0] w_total;

    assign w_total = r_sum + i_byte;

    always_comb begin
        n_phase = r_phase;
        n_id    = r_id;
        n_len   = r_len;
        n_seen  = r_seen;
        n_sum   = r_sum;
        o_push  = '0;
        o_push.res.message_id = r_id;
        case (r_phase)
            PH_HUNT1: begin
                if (i_byte == SYNC_B) begin
                    n_phase = PH_ID;
                end else if (i_byte == SYNC_A) begin
                    n_phase = PH_HUNT1;
                end else begin
                    n_phase = PH_HUNT0;
                end
            end
            PH_ID: begin
                n_id    = i_byte;
                n_sum   = SYNC_B + i_byte;
                n_phase = PH_LEN;
            end
            PH_LEN: begin
                n_len   = i_byte;
                n_seen  = '0;
                n_sum   = w_total;
                n_phase = (i_byte == 8'd0) ? PH_CSUM : PH_DATA;
            end
            PH_DATA: begin
                n_sum  = w_total;
                n_seen = r_seen + 8'd1;
                if (n_seen == r_len) begin
                    n_phase = PH_CSUM;
                end
                o_push.valid            = 1'b1;
                o_push.res.payload_byte = i_byte;
                o_push.res.byte_index   = r_seen;
            end
            PH_CSUM: begin
                n_phase = PH_HUNT0;
                o_push.valid            = 1'b1;
                o_push.res.byte_index   = r_len;
                o_push.res.frame_end    = 1'b1;
                o_push.res.checksum_ok  = (w_total == 8'd0);
            end
            default: begin
                n_phase = (i_byte == SYNC_A) ? PH_HUNT1 : PH_HUNT0;
            end
        endcase
        if (!i_take) begin
            o_push.valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT0;
            r_id    <= '0;
            r_len   <= '0;
            r_seen  <= '0;
            r_sum   <= '0;
        end else if (i_take) begin
            r_phase <= n_phase;
            r_id    <= n_id;
            r_len   <= n_len;
            r_seen  <= n_seen;
            r_sum   <= n_sum;
        end
    end

endmodule

FILE: sv/spd_fifo.sv
// Short result queue between the parser and the output stage.
// Depends on spd_pkg for the result type and depth.
module spd_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  spd_pkg::t_push   i_push,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_empty,
    output spd_pkg::t_result o_head
);
    import spd_pkg::*;

    t_result          r_mem [QDEPTH];
    logic [QAW-1:0]   r_wr, r_rd;
    logic [QCW-1:0]   r_cnt;
    logic             w_pop;

    assign o_full  = (r_cnt == QCW'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr] <= i_push.res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push.valid) begin
                r_wr <= (r_wr == QAW'(QDEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == QAW'(QDEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({i_push.valid, w_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

FILE: sv/spd_out.sv
// Back part: output register that drains the queue onto the master stream.
// Depends on spd_pkg for the result type.
module spd_out (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  spd_pkg::t_result i_head,
    input  logic             i_empty,
    output logic             o_pop,
    input  logic             i_m_axis_tready,
    output logic             o_m_axis_tvalid,
    output logic [23:0]      o_m_axis_tdata,
    output logic             o_m_axis_tlast,
    output logic             o_m_axis_tuser
);
    import spd_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_pop = !i_empty && (!r_valid || i_m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_res <= i_head;
        end
    end

    assign o_m_axis_tvalid = r_valid;
    assign o_m_axis_tdata  = {r_res.byte_index, r_res.payload_byte, r_res.message_id};
    assign o_m_axis_tlast  = r_res.frame_end;
    assign o_m_axis_tuser  = r_res.checksum_ok;

endmodule

FILE: sv/sensor_packet_deframer.sv
// Sensor packet deframer: one received byte per transfer, one result per data or checksum byte.
// Throughput: one byte per cycle; input stalls only when the four-entry result queue is full.
// Path: a result is written into the result queue as its byte is taken, then moves into the output register.
// Reset: synchronous active-low i_rst_n clears the parser state, the queue and the output valid.
// Depends on spd_pkg, spd_parser, spd_fifo and spd_out.
module sensor_packet_deframer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] rx_byte
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // [7:0] message_id, [15:8] payload_byte, [23:16] byte_index
    output logic        o_m_axis_tlast,   // frame_end
    output logic        o_m_axis_tuser    // [0] checksum_ok
);
    import spd_pkg::*;

    t_push   w_push;
    t_result w_head;
    logic    w_full;
    logic    w_empty;
    logic    w_pop;
    logic    w_take;

    assign o_s_axis_tready = !w_full;
    assign w_take          = i_s_axis_tvalid && !w_full;

    spd_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (w_take),
        .i_byte  (i_s_axis_tdata),
        .o_push  (w_push)
    );

    spd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_head  (w_head)
    );

    spd_out u_out (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (w_head),
        .i_empty         (w_empty),
        .o_pop           (w_pop),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

endmodule

FILE: sim/spd_deframe_checker.sv
`timescale 1ns / 100ps
// Result checker for sensor_packet_deframer: follows the byte and result streams,
// rebuilds each deframed result from the accepted bytes and compares them in order.
// Depends on spd_pkg for the result layout and the preamble bytes.
module spd_deframe_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] rx_byte
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [23:0] i_m_tdata,   // [7:0] message_id, [15:8] payload_byte, [23:16] byte_index
    input  logic        i_m_tlast,   // frame_end
    input  logic        i_m_tuser,   // [0] checksum_ok
    output int          o_fail_count,
    output int          o_pending
);
    import spd_pkg::*;

    typedef enum logic [2:0] {
        PH_HUNT      = 3'd0,
        PH_SYNC_SEEN = 3'd1,
        PH_ID        = 3'd2,
        PH_LEN       = 3'd3,
        PH_DATA      = 3'd4,
        PH_SUM       = 3'd5
    } t_phase;

    t_phase     phase;
    logic [7:0] frame_id;
    logic [7:0] frame_len;
    logic [7:0] data_count;
    logic [7:0] frame_sum;
    t_result    deframed_results[$];
    int         mismatch_count = 0;

    task automatic deframe_byte(input logic [7:0] rx);
        t_result r;
        r = '0;
        r.message_id = frame_id;
        case (phase)
            PH_SYNC_SEEN: begin
                if (rx == SYNC_B)
                    phase = PH_ID;
                else if (rx == SYNC_A)
                    phase = PH_SYNC_SEEN;
                else
                    phase = PH_HUNT;
            end
            PH_ID: begin
                frame_id  = rx;
                frame_sum = SYNC_B + rx;
                phase     = PH_LEN;
            end
            PH_LEN: begin
                frame_len  = rx;
                data_count = 8'd0;
                frame_sum  = frame_sum + rx;
                phase      = (rx == 8'd0) ? PH_SUM : PH_DATA;
            end
            PH_DATA: begin
                r.payload_byte = rx;
                r.byte_index   = data_count;
                frame_sum      = frame_sum + rx;
                data_count     = data_count + 8'd1;
                if (data_count == frame_len)
                    phase = PH_SUM;
                deframed_results = {deframed_results, r};
            end
            PH_SUM: begin
                r.byte_index  = frame_len;
                r.frame_end   = 1'b1;
                r.checksum_ok = (8'(frame_sum + rx) == 8'd0);
                phase         = PH_HUNT;
                deframed_results = {deframed_results, r};
            end
            default: begin
                phase = (rx == SYNC_A) ? PH_SYNC_SEEN : PH_HUNT;
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_result want;
        if (!i_rst_n) begin
            phase      = PH_HUNT;
            frame_id   = 8'd0;
            frame_len  = 8'd0;
            data_count = 8'd0;
            frame_sum  = 8'd0;
            deframed_results.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (deframed_results.size() == 0) begin
                    $error("result with none pending: tdata %h tlast %b tuser %b",
                           i_m_tdata, i_m_tlast, i_m_tuser);
                    mismatch_count++;
                end else begin
                    want = deframed_results.pop_front();
                    check_field("message_id", want.message_id, i_m_tdata[7:0]);
                    check_field("payload_byte", want.payload_byte, i_m_tdata[15:8]);
                    check_field("byte_index", want.byte_index, i_m_tdata[23:16]);
                    check_field("frame_end", 8'(want.frame_end), 8'(i_m_tlast));
                    check_field("checksum_ok", 8'(want.checksum_ok), 8'(i_m_tuser));
                end
            end
            if (i_s_tvalid && i_s_tready)
                deframe_byte(i_s_tdata);
        end
        o_pending    <= deframed_results.size();
        o_fail_count <= mismatch_count;
    end

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 100ps
// Testbench top for sensor_packet_deframer: builds the received byte stream,
// drives it with random gaps and output stalls, and gives the verdict.
// Depends on spd_pkg, the deframer RTL and spd_deframe_checker.
module tb_top;
    import spd_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [7:0]  s_tdata = 8'd0;
    logic        s_tready;
    logic        m_tvalid;
    logic        m_tready = 1'b1;
    logic [23:0] m_tdata;   // [7:0] message_id, [15:8] payload_byte, [23:16] byte_index
    logic        m_tlast;   // frame_end
    logic        m_tuser;   // [0] checksum_ok
    int          fail_count;
    int          pending;
    bit          quiet = 1'b0;
    logic [7:0]  wire_bytes[$];

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    sensor_packet_deframer u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tlast  (m_tlast),
        .o_m_axis_tuser  (m_tuser)
    );

    spd_deframe_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tlast    (m_tlast),
        .i_m_tuser    (m_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 7))
            0:       return SYNC_A;
            1:       return SYNC_B;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic append_byte(input logic [7:0] b);
        wire_bytes = {wire_bytes, b};
    endtask

    task automatic add_frame(input logic [7:0] id, input int len, input int keep,
                             input bit bad_sum);
        logic [7:0] sum;
        logic [7:0] d;
        sum = SYNC_B + id + 8'(len);
        append_byte(SYNC_A);
        append_byte(SYNC_B);
        append_byte(id);
        append_byte(8'(len));
        for (int k = 0; k < keep; k++) begin
            d   = rand_byte();
            sum = sum + d;
            append_byte(d);
        end
        if (keep == len) begin
            if (bad_sum)
                append_byte(8'(8'd0 - sum) ^ 8'($urandom_range(1, 255)));
            else
                append_byte(8'(8'd0 - sum));
        end
    endtask

    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 19);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do
            @(posedge clk);
        while (!(s_tvalid && s_tready));
        @(negedge clk);
    endtask

    initial begin : sink_ready
        int n;
        forever begin
            @(negedge clk);
            if (!quiet && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 19);
                m_tready <= 1'b0;
                repeat (n) @(negedge clk);
                m_tready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        int goal;
        int frames;
        int len;
        // noise, broken preamble, repeated sync with empty frame, bad sum with
        // extreme data, then a checksum byte of FA followed by FF
        wire_bytes = {8'h00, 8'h55, SYNC_A, 8'h12,
                      SYNC_A, SYNC_A, SYNC_B, 8'h00, 8'h00, 8'h01,
                      SYNC_A, SYNC_B, 8'hFF, 8'h02, 8'h00, 8'hFF, 8'h00,
                      SYNC_A, SYNC_B, 8'h07, 8'h00, SYNC_A, SYNC_B};
        goal   = wire_bytes.size() + 400;
        frames = 0;
        while (wire_bytes.size() < goal) begin
            len = ($urandom_range(0, 15) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
            if (frames == 4) begin
                add_frame(rand_byte(), 255, 255, 1'b0);
            end else begin
                case ($urandom_range(0, 9))
                    0: repeat ($urandom_range(1, 4)) append_byte(rand_byte());
                    1: add_frame(rand_byte(), len + 1, $urandom_range(0, len), 1'b0);
                    2: add_frame(rand_byte(), len, len, 1'b1);
                    default: add_frame(rand_byte(), len, len, 1'b0);
                endcase
            end
            frames++;
        end

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int k = 0; k < wire_bytes.size(); k++) begin
            quiet = (wire_bytes.size() - k) <= 60;
            send_byte(wire_bytes[k]);
        end
        s_tvalid <= 1'b0;

        while (pending != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial begin : watchdog
        #2000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: filelist.f
sv/spd_pkg.sv
sv/spd_parser.sv
sv/spd_fifo.sv
sv/spd_out.sv
sv/sensor_packet_deframer.sv
sim/spd_deframe_checker.sv
sim/tb_top.sv
